[rtl/core/hcomp_pkg.sv]
// ----------------------------------------------------------------------------
// hcomp_pkg
// Constants shared by the humidity compensation datapath: register indexes,
// fixed offsets and rounding terms, and 32-bit wrapping arithmetic helpers.
// ----------------------------------------------------------------------------
package hcomp_pkg;

    localparam int unsigned ADC_W    = 16;
    localparam int unsigned TEMP_W   = 20;
    localparam int unsigned HUM_W    = 17;
    localparam int unsigned IDX_W    = 3;
    localparam int unsigned CFG_W    = 16;
    localparam int unsigned WORD_W   = 32;

    localparam logic [IDX_W-1:0] REG_H1 = 3'd0;
    localparam logic [IDX_W-1:0] REG_H2 = 3'd1;
    localparam logic [IDX_W-1:0] REG_H3 = 3'd2;
    localparam logic [IDX_W-1:0] REG_H4 = 3'd3;
    localparam logic [IDX_W-1:0] REG_H5 = 3'd4;
    localparam logic [IDX_W-1:0] REG_H6 = 3'd5;

    localparam logic [WORD_W-1:0] T_OFFSET  = 32'd76800;
    localparam logic [WORD_W-1:0] ROUND15   = 32'd16384;
    localparam logic [WORD_W-1:0] H3_BIAS   = 32'd32768;
    localparam logic [WORD_W-1:0] GAIN_BIAS = 32'd2097152;
    localparam logic [WORD_W-1:0] ROUND14   = 32'd8192;
    localparam logic [WORD_W-1:0] CLAMP_MAX = 32'd419430400;

    localparam logic [7:0]  BYTE_ONES = 8'hFF;
    localparam logic [11:0] H12_ONES  = 12'hFFF;
    localparam logic [15:0] H16_ONES  = 16'hFFFF;

    // Low 32 bits of a 32 x 32 product; identical for signed and unsigned.
    function automatic logic [WORD_W-1:0] wmul(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
        logic [2*WORD_W-1:0] full;
        full = a * b;
        return full[WORD_W-1:0];
    endfunction

    function automatic logic [WORD_W-1:0] asr(logic [WORD_W-1:0] x, logic [4:0] n);
        logic signed [WORD_W-1:0] sx;
        sx = $signed(x);
        return WORD_W'(sx >>> n);
    endfunction

endpackage

[rtl/core/humidity_compensation.sv]
// ----------------------------------------------------------------------------
// humidity_compensation
// Nine-stage pipelined 32-bit integer humidity compensation.
// ----------------------------------------------------------------------------
// Usage: pulse start with adc_humidity and temperature_fine; one sample is
// taken every cycle (busy stays low). Each result appears on humidity_q10 and
// calibration_valid once the sample has left the pipe, marked by done for one
// cycle, in order; the receiver cannot stall it. Latency is set by the chain
// of dependent 32-bit multiplies, at most one per pipeline stage. Write
// coefficients through wr_en/wr_index/wr_data only while no sample is in flight.
module humidity_compensation
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [hcomp_pkg::ADC_W-1:0]      adc_humidity,
    input  logic [hcomp_pkg::TEMP_W-1:0]     temperature_fine,
    output logic                             done,
    output logic [hcomp_pkg::HUM_W-1:0]      humidity_q10,
    output logic                             calibration_valid,
    input  logic                             wr_en,
    input  logic [hcomp_pkg::IDX_W-1:0]      wr_index,
    input  logic [hcomp_pkg::CFG_W-1:0]      wr_data
);
    import hcomp_pkg::*;

    localparam int unsigned STAGES = 9;

    logic [7:0]  coef_h1_reg;
    logic [15:0] coef_h2_reg;
    logic [7:0]  coef_h3_reg;
    logic [11:0] coef_h4_reg;
    logic [11:0] coef_h5_reg;
    logic [7:0]  coef_h6_reg;

    logic [WORD_W-1:0] h1, h2, h3, h4, h5, h6;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;

    logic [WORD_W-1:0] t1_reg, t1_next;
    logic [ADC_W-1:0]  adc1_reg;

    logic [WORD_W-1:0] base2_reg, base2_next;
    logic [WORD_W-1:0] h5t2_reg, h5t2_next;
    logic [WORD_W-1:0] t62_reg, t62_next;
    logic [WORD_W-1:0] t32_reg, t32_next;

    logic [WORD_W-1:0] a3_reg, a3_next;
    logic [WORD_W-1:0] x3_reg, x3_next;
    logic [WORD_W-1:0] y3_reg, y3_next;

    logic [WORD_W-1:0] a4_reg;
    logic [WORD_W-1:0] bm4_reg, bm4_next;

    logic [WORD_W-1:0] a5_reg;
    logic [WORD_W-1:0] p5_reg, p5_next;

    logic [WORD_W-1:0] v6_reg, v6_next;

    logic [WORD_W-1:0] v7_reg;
    logic [WORD_W-1:0] qq7_reg, qq7_next;

    logic [WORD_W-1:0] v8_reg;
    logic [WORD_W-1:0] q8_reg, q8_next;

    logic [WORD_W-1:0] d9;
    logic [WORD_W-1:0] clamp9;
    logic [HUM_W-1:0]  hum_reg, hum_next;
    logic              cal_ok;
    logic              cal_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_h1_reg <= '0;
            coef_h2_reg <= '0;
            coef_h3_reg <= '0;
            coef_h4_reg <= '0;
            coef_h5_reg <= '0;
            coef_h6_reg <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_H1:  coef_h1_reg <= wr_data[7:0];
                REG_H2:  coef_h2_reg <= wr_data[15:0];
                REG_H3:  coef_h3_reg <= wr_data[7:0];
                REG_H4:  coef_h4_reg <= wr_data[11:0];
                REG_H5:  coef_h5_reg <= wr_data[11:0];
                REG_H6:  coef_h6_reg <= wr_data[7:0];
                default: ;
            endcase
        end
    end

    assign h1 = {24'd0, coef_h1_reg};
    assign h2 = {{16{coef_h2_reg[15]}}, coef_h2_reg};
    assign h3 = {24'd0, coef_h3_reg};
    assign h4 = {{20{coef_h4_reg[11]}}, coef_h4_reg};
    assign h5 = {{20{coef_h5_reg[11]}}, coef_h5_reg};
    assign h6 = {{24{coef_h6_reg[7]}}, coef_h6_reg};

    assign cal_ok = !(coef_h1_reg == BYTE_ONES && coef_h2_reg == H16_ONES &&
                      coef_h3_reg == BYTE_ONES && coef_h4_reg == H12_ONES &&
                      coef_h5_reg == H12_ONES  && coef_h6_reg == BYTE_ONES);

    assign valid_next = {valid_reg[STAGES-2:0], start};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Datapath
    always_comb
    begin
        t1_next    = {{(WORD_W-TEMP_W){temperature_fine[TEMP_W-1]}}, temperature_fine}
                     - T_OFFSET;

        base2_next = ({16'd0, adc1_reg} << 14) - (h4 << 20);
        h5t2_next  = wmul(h5, t1_reg);
        t62_next   = wmul(t1_reg, h6);
        t32_next   = wmul(t1_reg, h3);

        a3_next    = asr(base2_reg - h5t2_reg + ROUND15, 5'd15);
        x3_next    = asr(t62_reg, 5'd10);
        y3_next    = asr(t32_reg, 5'd11) + H3_BIAS;

        bm4_next   = wmul(x3_reg, y3_reg);

        p5_next    = wmul(asr(bm4_reg, 5'd10) + GAIN_BIAS, h2);

        v6_next    = wmul(a5_reg, asr(p5_reg + ROUND14, 5'd14));

        qq7_next   = wmul(asr(v6_reg, 5'd15), asr(v6_reg, 5'd15));

        q8_next    = wmul(asr(qq7_reg, 5'd7), h1);

        // Subtract the quadratic term, then clamp to 0..CLAMP_MAX
        d9 = v8_reg - asr(q8_reg, 5'd4);
        if (d9[WORD_W-1])
            clamp9 = '0;
        else if (d9 > CLAMP_MAX)
            clamp9 = CLAMP_MAX;
        else
            clamp9 = d9;
        hum_next = clamp9[12 +: HUM_W];
    end

    always_ff @(posedge clk)
    begin
        t1_reg    <= t1_next;
        adc1_reg  <= adc_humidity;

        base2_reg <= base2_next;
        h5t2_reg  <= h5t2_next;
        t62_reg   <= t62_next;
        t32_reg   <= t32_next;

        a3_reg    <= a3_next;
        x3_reg    <= x3_next;
        y3_reg    <= y3_next;

        a4_reg    <= a3_reg;
        bm4_reg   <= bm4_next;

        a5_reg    <= a4_reg;
        p5_reg    <= p5_next;

        v6_reg    <= v6_next;

        v7_reg    <= v6_reg;
        qq7_reg   <= qq7_next;

        v8_reg    <= v7_reg;
        q8_reg    <= q8_next;

        hum_reg   <= hum_next;
        cal_reg   <= cal_ok;
    end

    assign busy              = 1'b0;
    assign done              = valid_reg[STAGES-1];
    assign humidity_q10      = hum_reg;
    assign calibration_valid = cal_reg;

endmodule

[test/humidity_compensation_test.sv]
// ----------------------------------------------------------------------------
// humidity_compensation_test
// Self-checking bench for the integer humidity compensation pipeline. Drives
// raw humidity and fine temperature samples under several calibrations,
// predicts each reading with 32-bit wrapping arithmetic and compares it
// field by field with the result the block returns.
// ----------------------------------------------------------------------------
module humidity_compensation_test;

    import hcomp_pkg::*;

    localparam int TEMP_OFFSET  = 76800;
    localparam int H4_SCALE     = 1048576;
    localparam int ROUND_15     = 16384;
    localparam int H3_OFFSET    = 32768;
    localparam int GAIN_OFFSET  = 2097152;
    localparam int ROUND_14     = 8192;
    localparam int RH_CEILING   = 419430400;
    localparam int PIPE_SLACK   = 12;
    localparam int BLOCK_ITEMS  = 108;

    localparam logic [IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [IDX_W-1:0] REG_SPARE_B = 3'd7;

    typedef struct packed {
        logic [HUM_W-1:0] humidity;
        logic             cal_ok;
    } reading_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [ADC_W-1:0]   adc_humidity;
    logic [TEMP_W-1:0]  temperature_fine;
    logic               done;
    logic [HUM_W-1:0]   humidity_q10;
    logic               calibration_valid;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_index;
    logic [CFG_W-1:0]   wr_data;

    // Shadow copy of the calibration registers
    logic [7:0]         cal_h1;
    logic [15:0]        cal_h2;
    logic [7:0]         cal_h3;
    logic [11:0]        cal_h4;
    logic [11:0]        cal_h5;
    logic [7:0]         cal_h6;

    reading_t           expected_readings[$];
    int                 error_count;
    int                 sender_idle_pct;
    int                 block_count;

    humidity_compensation dut
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .adc_humidity      (adc_humidity),
        .temperature_fine  (temperature_fine),
        .done              (done),
        .humidity_q10      (humidity_q10),
        .calibration_valid (calibration_valid),
        .wr_en             (wr_en),
        .wr_index          (wr_index),
        .wr_data           (wr_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    initial
    begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic reading_t compensate_humidity(logic [ADC_W-1:0] adc,
                                                     logic [TEMP_W-1:0] tf);
        int       h1, h2, h3, h4, h5, h6;
        int       t, a, b, v, q;
        reading_t r;
        h1 = int'(cal_h1);
        h2 = int'($signed(cal_h2));
        h3 = int'(cal_h3);
        h4 = int'($signed(cal_h4));
        h5 = int'($signed(cal_h5));
        h6 = int'($signed(cal_h6));
        t = int'($signed(tf)) - TEMP_OFFSET;
        // Every product and sum wraps at 32 bits, every shift is arithmetic
        a = (int'(adc) << 14) - h4 * H4_SCALE - h5 * t;
        a = (a + ROUND_15) >>> 15;
        b = ((t * h6) >>> 10) * (((t * h3) >>> 11) + H3_OFFSET);
        b = (b >>> 10) + GAIN_OFFSET;
        b = (b * h2 + ROUND_14) >>> 14;
        v = a * b;
        q = v >>> 15;
        q = (q * q) >>> 7;
        q = (q * h1) >>> 4;
        v = v - q;
        if (v < 0)
        begin
            v = 0;
        end
        else if (v > RH_CEILING)
        begin
            v = RH_CEILING;
        end
        r.humidity = HUM_W'(v >>> 12);
        r.cal_ok = !(cal_h1 == BYTE_ONES && cal_h2 == H16_ONES && cal_h3 == BYTE_ONES &&
                     cal_h4 == H12_ONES && cal_h5 == H12_ONES && cal_h6 == BYTE_ONES);
        return r;
    endfunction

    // Compare every returned reading with the oldest one predicted
    always @(posedge clk)
    begin : check_readings
        reading_t want;
        if (rst_n && done)
        begin
            if (expected_readings.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result, expected none, actual humidity_q10=%0d cal=%0b",
                         $time, humidity_q10, calibration_valid);
            end
            else
            begin
                want = expected_readings.pop_front();
                if (humidity_q10 !== want.humidity)
                begin
                    error_count++;
                    $display("%0t: humidity_q10 mismatch, expected %0d, actual %0d",
                             $time, want.humidity, humidity_q10);
                end
                if (calibration_valid !== want.cal_ok)
                begin
                    error_count++;
                    $display("%0t: calibration_valid mismatch, expected %0b, actual %0b",
                             $time, want.cal_ok, calibration_valid);
                end
            end
        end
    end

    task automatic write_coef(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= data;
        @(posedge clk);
        wr_en <= 1'b0;
        case (idx)
            REG_H1: cal_h1 = data[7:0];
            REG_H2: cal_h2 = data[15:0];
            REG_H3: cal_h3 = data[7:0];
            REG_H4: cal_h4 = data[11:0];
            REG_H5: cal_h5 = data[11:0];
            REG_H6: cal_h6 = data[7:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic load_calibration(input int h1, input int h2, input int h3,
                                    input int h4, input int h5, input int h6);
        write_coef(REG_H1, CFG_W'(h1));
        write_coef(REG_H2, CFG_W'(h2));
        write_coef(REG_H3, CFG_W'(h3));
        write_coef(REG_H4, CFG_W'(h4));
        write_coef(REG_H5, CFG_W'(h5));
        write_coef(REG_H6, CFG_W'(h6));
    endtask

    task automatic send_sample(input logic [ADC_W-1:0] adc, input logic [TEMP_W-1:0] tf);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        adc_humidity <= adc;
        temperature_fine <= tf;
        do
            @(posedge clk);
        while (busy);
        expected_readings.push_back(compensate_humidity(adc, tf));
    endtask

    // Drop start and hold until every reading is back and the pipe is empty
    task automatic drain_pipeline();
        start <= 1'b0;
        while (expected_readings.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (PIPE_SLACK) @(posedge clk);
    endtask

    function automatic logic [TEMP_W-1:0] random_temperature();
        case ($urandom_range(3))
            0: return TEMP_W'($urandom());
            1, 2: return TEMP_W'(int'($urandom_range(640000)) - 204800);
            default: return TEMP_W'(TEMP_OFFSET + int'($urandom_range(2048)) - 1024);
        endcase
    endfunction

    function automatic logic [ADC_W-1:0] random_adc();
        case ($urandom_range(15))
            0: return '0;
            1: return '1;
            default: return ADC_W'($urandom());
        endcase
    endfunction

    task automatic random_calibration();
        block_count++;
        if (block_count % 6 == 0)
        begin
            load_calibration(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        end
        else if ($urandom_range(3) == 0)
        begin
            // Full 16-bit data so the upper bits get masked off
            load_calibration($urandom(), $urandom(), $urandom(),
                             $urandom(), $urandom(), $urandom());
        end
        else
        begin
            load_calibration($urandom_range(255), 300 + $urandom_range(150),
                             $urandom_range(255), 250 + $urandom_range(150),
                             $urandom_range(100), $urandom_range(60));
        end
        write_coef($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, CFG_W'($urandom()));
    endtask

    task automatic test_reset_defaults();
        send_sample('1, TEMP_W'(-524288));
        send_sample('0, TEMP_W'(524287));
        send_sample(16'h6A00, TEMP_W'(128000));
        drain_pipeline();
    endtask

    task automatic test_register_writes();
        // Writes to indexes past the list must leave the coefficients alone
        write_coef(REG_SPARE_A, 16'hFFFF);
        write_coef(REG_SPARE_B, 16'hFFFF);
        load_calibration(16'hFF4B, 16'h0172, 16'hA500, 16'hF139, 16'h3032, 16'h551E);
        send_sample(16'h6A00, TEMP_W'(128000));
        drain_pipeline();
    endtask

    task automatic test_typical_calibration();
        load_calibration(75, 370, 0, 313, 50, 30);
        send_sample('0, TEMP_W'(TEMP_OFFSET));
        send_sample('1, TEMP_W'(TEMP_OFFSET));
        send_sample(16'd26000, TEMP_W'(128000));
        send_sample(16'h8000, TEMP_W'(-524288));
        send_sample(16'h7FFF, TEMP_W'(524287));
        send_sample(16'h5555, '0);
        send_sample(16'hAAAA, TEMP_W'(-1));
        drain_pipeline();
    endtask

    task automatic test_unprogrammed_calibration();
        load_calibration(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_sample(16'd30000, TEMP_W'(128000));
        send_sample('1, TEMP_W'(-524288));
        drain_pipeline();
        // One coefficient off the erased pattern is a programmed part
        write_coef(REG_H6, 16'h00FE);
        send_sample(16'd30000, TEMP_W'(128000));
        drain_pipeline();
    endtask

    task automatic test_calibration_extremes();
        load_calibration(0, -32768, 0, -2048, -2048, -128);
        send_sample('1, TEMP_W'(524287));
        send_sample('0, TEMP_W'(-524288));
        send_sample(16'h9C40, TEMP_W'(TEMP_OFFSET));
        drain_pipeline();
        load_calibration(255, 32767, 255, 2047, 2047, 127);
        send_sample('1, TEMP_W'(524287));
        send_sample('0, TEMP_W'(-524288));
        send_sample(16'h9C40, TEMP_W'(TEMP_OFFSET));
        drain_pipeline();
    endtask

    task automatic test_random_traffic(input int idle_pct);
        sender_idle_pct = idle_pct;
        repeat (4)
        begin
            random_calibration();
            repeat (BLOCK_ITEMS)
            begin
                send_sample(random_adc(), random_temperature());
            end
            drain_pipeline();
        end
    endtask

    initial
    begin
        error_count = 0;
        block_count = 0;
        sender_idle_pct = 0;
        cal_h1 = '0;
        cal_h2 = '0;
        cal_h3 = '0;
        cal_h4 = '0;
        cal_h5 = '0;
        cal_h6 = '0;
        rst_n <= 1'b0;
        start <= 1'b0;
        adc_humidity <= '0;
        temperature_fine <= '0;
        wr_en <= 1'b0;
        wr_index <= '0;
        wr_data <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_register_writes();
        test_typical_calibration();
        test_unprogrammed_calibration();
        test_calibration_extremes();
        test_random_traffic(11);
        test_random_traffic(47);
        test_random_traffic(0);

        if (error_count == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
